### design/assert_macros.svh
// Assertion macros shared by the vertex transform RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset.
`define VTPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vtpd: assertion failed");

// Check a property on every edge, reset included.
`define VTPD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("vtpd: assertion failed");

`endif

### design/vtpd_pkg.sv
// Shared types and constants for the vertex transform and perspective divide.
package vtpd_pkg;

  localparam int COORD_W   = 32;
  localparam int COEF_W    = 16;
  localparam int SLOT_W    = 16;
  localparam int FRAC_W    = 16;
  localparam int COEF_FRAC = 12;
  localparam int ROW_W     = 4 * SLOT_W;
  localparam int PROD_W    = COORD_W + COEF_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int NUM_W     = COORD_W + FRAC_W;
  localparam int QBITS     = COORD_W + 1;
  localparam int NLANE     = 3;

  typedef logic [COORD_W-1:0] coord_t;
  typedef coord_t [3:0] vec_t;
  typedef logic [3:0][ROW_W-1:0] rows_t;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_VIEW_ROW0 = 3'd0;
  localparam cfg_idx_t REG_VIEW_ROW1 = 3'd1;
  localparam cfg_idx_t REG_VIEW_ROW2 = 3'd2;
  localparam cfg_idx_t REG_VIEW_ROW3 = 3'd3;
  localparam cfg_idx_t REG_PROJ_ROW0 = 3'd4;
  localparam cfg_idx_t REG_PROJ_ROW1 = 3'd5;
  localparam cfg_idx_t REG_PROJ_ROW2 = 3'd6;
  localparam cfg_idx_t REG_PROJ_ROW3 = 3'd7;

  // Identity matrix, 1.0 in Q4.12 on the diagonal.
  localparam rows_t ROWS_IDENTITY = {64'h1000_0000_0000_0000, 64'h0000_1000_0000_0000,
                                     64'h0000_0000_1000_0000, 64'h0000_0000_0000_1000};

  localparam coord_t ONE_FIXED = coord_t'(1) << FRAC_W;

  // Sideband carried with each vertex.
  typedef struct packed {
    logic batch_end;
    logic sat;
  } tag_t;

  // Divider control carried through the bit stages.
  typedef struct packed {
    tag_t               tag;
    logic               wz;
    logic [COORD_W-1:0] aw;
    logic [NLANE-1:0]   neg;
    logic [NLANE-1:0]   ovf;
  } divc_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QBITS-1:0] q;
  } lane_t;

endpackage

### design/vtpd_mat.sv
// Two-stage 4x4 matrix multiply with Q4.12 rounding and coordinate saturation.
module vtpd_mat (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  vtpd_pkg::tag_t in_tag,
  input  vtpd_pkg::vec_t in_vec,
  input  vtpd_pkg::rows_t rows,
  output logic           out_vld,
  output vtpd_pkg::tag_t out_tag,
  output vtpd_pkg::vec_t out_vec
);
  import vtpd_pkg::*;

  logic               vld1_r;
  tag_t               tag1_r;
  logic signed [PROD_W-1:0] prod_r [4][4];
  logic               vld2_r;
  tag_t               tag2_r, tag2_nxt;
  vec_t               vec2_r, vec2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  // Stage 1: the sixteen products.
  always_ff @(posedge clk) begin
    if (adv) begin
      tag1_r <= in_tag;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod_r[i][j] <= $signed(in_vec[i]) *
                          $signed(rows[i][SLOT_W*j +: COEF_W]);
        end
      end
    end
  end

  // Stage 2: exact column sums, round half up, clamp.
  always_comb begin
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] hi_lim;
    logic signed [SUM_W-1:0] lo_lim;
    hi_lim   = SUM_W'((64'sd1 <<< (COORD_W-1)) - 64'sd1);
    lo_lim   = -hi_lim - SUM_W'(1);
    tag2_nxt = tag1_r;
    vec2_nxt = '0;
    for (int j = 0; j < 4; j++) begin
      s = SUM_W'(prod_r[0][j]) + SUM_W'(prod_r[1][j]) + SUM_W'(prod_r[2][j])
        + SUM_W'(prod_r[3][j]) + (SUM_W'(1) <<< (COEF_FRAC-1));
      s = s >>> COEF_FRAC;
      if (s > hi_lim) begin
        vec2_nxt[j]  = hi_lim[COORD_W-1:0];
        tag2_nxt.sat = 1'b1;
      end else if (s < lo_lim) begin
        vec2_nxt[j]  = lo_lim[COORD_W-1:0];
        tag2_nxt.sat = 1'b1;
      end else begin
        vec2_nxt[j] = s[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag2_r <= tag2_nxt;
      vec2_r <= vec2_nxt;
    end
  end

  assign out_vld = vld2_r;
  assign out_tag = tag2_r;
  assign out_vec = vec2_r;

endmodule

### design/vtpd_div.sv
// Pipelined restoring divider: one quotient bit per stage, three lanes sharing w.
module vtpd_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  vtpd_pkg::tag_t in_tag,
  input  vtpd_pkg::vec_t in_vec,
  output logic           out_vld,
  output vtpd_pkg::tag_t out_tag,
  output logic           out_wz,
  output vtpd_pkg::vec_t out_vec
);
  import vtpd_pkg::*;

  logic  vld_r  [QBITS+1];
  divc_t ctl_r  [QBITS+1];
  lane_t lane_r [QBITS+1][NLANE];
  divc_t ctl0_nxt;
  lane_t lane0_nxt [NLANE];

  logic  fin_vld_r;
  tag_t  fin_tag_r, fin_tag_nxt;
  logic  fin_wz_r;
  vec_t  fin_vec_r, fin_vec_nxt;

  // Prep: magnitudes, scaled dividend with half-divisor bias, overflow check.
  always_comb begin
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] ma;
    logic [NUM_W-1:0]   n;
    w            = in_vec[3];
    ctl0_nxt.tag = in_tag;
    ctl0_nxt.wz  = (w == '0);
    ctl0_nxt.aw  = w[COORD_W-1] ? (~w + COORD_W'(1)) : w;
    for (int l = 0; l < NLANE; l++) begin
      ma = in_vec[l][COORD_W-1] ? (~in_vec[l] + COORD_W'(1)) : in_vec[l];
      n  = {ma, FRAC_W'(0)} + NUM_W'(ctl0_nxt.aw >> 1);
      ctl0_nxt.neg[l]  = in_vec[l][COORD_W-1] ^ w[COORD_W-1];
      ctl0_nxt.ovf[l]  = COORD_W'(n >> QBITS) >= ctl0_nxt.aw;
      lane0_nxt[l].rem = n;
      lane0_nxt[l].q   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[0] <= ctl0_nxt;
      for (int l = 0; l < NLANE; l++) begin
        lane_r[0][l] <= lane0_nxt[l];
      end
    end
  end

  for (genvar s = 0; s < QBITS; s++) begin : g_step
    localparam int K = QBITS - 1 - s;
    lane_t step_nxt [NLANE];

    always_comb begin
      for (int l = 0; l < NLANE; l++) begin
        step_nxt[l] = lane_r[s][l];
        if ((lane_r[s][l].rem >> K) >= NUM_W'(ctl_r[s].aw)) begin
          step_nxt[l].rem  = lane_r[s][l].rem - (NUM_W'(ctl_r[s].aw) << K);
          step_nxt[l].q[K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (adv) begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ctl_r[s+1] <= ctl_r[s];
        for (int l = 0; l < NLANE; l++) begin
          lane_r[s+1][l] <= step_nxt[l];
        end
      end
    end
  end

  // Final: apply sign, clamp, zero on w == 0.
  always_comb begin
    logic [QBITS-1:0] q;
    logic [QBITS-1:0] lim;
    lim         = QBITS'(1) << (COORD_W-1);
    fin_tag_nxt = ctl_r[QBITS].tag;
    fin_vec_nxt = '0;
    for (int l = 0; l < NLANE; l++) begin
      q = lane_r[QBITS][l].q;
      if (ctl_r[QBITS].wz) begin
        fin_vec_nxt[l] = '0;
      end else if (ctl_r[QBITS].neg[l]) begin
        if (ctl_r[QBITS].ovf[l] || q > lim) begin
          fin_vec_nxt[l]  = lim[COORD_W-1:0];
          fin_tag_nxt.sat = 1'b1;
        end else begin
          fin_vec_nxt[l] = ~q[COORD_W-1:0] + COORD_W'(1);
        end
      end else begin
        if (ctl_r[QBITS].ovf[l] || q > lim - QBITS'(1)) begin
          fin_vec_nxt[l]  = lim[COORD_W-1:0] - COORD_W'(1);
          fin_tag_nxt.sat = 1'b1;
        end else begin
          fin_vec_nxt[l] = q[COORD_W-1:0];
        end
      end
    end
    fin_vec_nxt[3] = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (adv) begin
      fin_vld_r <= vld_r[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_tag_r <= fin_tag_nxt;
      fin_wz_r  <= ctl_r[QBITS].wz;
      fin_vec_r <= fin_vec_nxt;
    end
  end

  assign out_vld = fin_vld_r;
  assign out_tag = fin_tag_r;
  assign out_wz  = fin_wz_r;
  assign out_vec = fin_vec_r;

endmodule

### design/vertex_transform_perspective_divide.sv
// Top level: config registers, view and projection multiply, perspective divide.
// One vertex (x, y, z in signed Q16.16) enters per word and leaves as x/w, y/w,
// z/w in Q16.16. The block takes a new word every cycle unless stalled; the
// whole pipeline moves as one, so a stall on the result side (out_tready low
// while out_tvalid is high) holds every stage and stops intake. The divider
// resolves one of 33 quotient bits per stage; each matrix takes two stages
// (products, then rounded sums) and the divider adds one prep and one output
// stage. Matrix rows are written through cfg_we/cfg_addr/cfg_wdata (0..3 view
// rows, 4..7 projection rows, reset to identity) and must only change while no
// vertex is in flight. out_tuser bit 0 is w_zero (coordinates then zero), bit 1
// flags any clamp along the way.
module vertex_transform_perspective_divide (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // vertex_x, vertex_y, vertex_z
  input  logic        in_tlast,   // batch_end_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // ndc_x, ndc_y, ndc_z
  output logic [1:0]  out_tuser,  // w_zero, saturated
  output logic        out_tlast   // batch_end_out
);
  import vtpd_pkg::*;

  `include "assert_macros.svh"

  rows_t view_r, proj_r;
  logic  adv;

  tag_t  in_tag;
  vec_t  in_vec;
  logic  m1_vld, m2_vld, d_vld;
  tag_t  m1_tag, m2_tag, d_tag;
  vec_t  m1_vec, m2_vec, d_vec;
  logic  d_wz;

  // Register writes; no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r <= ROWS_IDENTITY;
      proj_r <= ROWS_IDENTITY;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_VIEW_ROW0: view_r[0] <= cfg_wdata;
        REG_VIEW_ROW1: view_r[1] <= cfg_wdata;
        REG_VIEW_ROW2: view_r[2] <= cfg_wdata;
        REG_VIEW_ROW3: view_r[3] <= cfg_wdata;
        REG_PROJ_ROW0: proj_r[0] <= cfg_wdata;
        REG_PROJ_ROW1: proj_r[1] <= cfg_wdata;
        REG_PROJ_ROW2: proj_r[2] <= cfg_wdata;
        REG_PROJ_ROW3: proj_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance everything when the output slot is empty or being drained.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Extend to the row vector (x, y, z, 1.0).
  assign in_tag.batch_end = in_tlast;
  assign in_tag.sat       = 1'b0;
  assign in_vec = {ONE_FIXED, in_tdata[95:64], in_tdata[63:32], in_tdata[31:0]};

  vtpd_mat u_view (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(in_tvalid), .in_tag(in_tag), .in_vec(in_vec), .rows(view_r),
    .out_vld(m1_vld), .out_tag(m1_tag), .out_vec(m1_vec)
  );

  vtpd_mat u_proj (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(m1_vld), .in_tag(m1_tag), .in_vec(m1_vec), .rows(proj_r),
    .out_vld(m2_vld), .out_tag(m2_tag), .out_vec(m2_vec)
  );

  vtpd_div u_div (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(m2_vld), .in_tag(m2_tag), .in_vec(m2_vec),
    .out_vld(d_vld), .out_tag(d_tag), .out_wz(d_wz), .out_vec(d_vec)
  );

  // The divider's last stage is the output register.
  assign out_tvalid = d_vld;
  assign out_tdata  = {d_vec[2], d_vec[1], d_vec[0]};
  assign out_tuser  = {d_tag.sat, d_wz};
  assign out_tlast  = d_tag.batch_end;

  `VTPD_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_tvalid)
  `VTPD_ASSERT(a_empty_accepts, !out_tvalid |-> in_tready)
  `VTPD_ASSERT(a_wz_zero_coords, (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))

endmodule
